// ===== src/id3eh_pkg.sv =====
// Shared types and constants for the ID3v2.4 extended header parser.
// No dependencies; imported by the front, queue, back and top modules.
package id3eh_pkg;

   localparam int MIN_SIZE      = 6;
   localparam int UPDATE_LEN    = 0;
   localparam int CRC_LEN       = 5;
   localparam int RESTRICT_LEN  = 1;
   localparam int CRC_SEG_BYTES = 6;
   localparam int RES_SEG_BYTES = 2;
   localparam int SIZE_BYTES    = 4;
   localparam int FLAG_COUNT_POS = 4;
   localparam int FLAG_BYTE_POS = 5;

   localparam int FLAG_UPDATE_BIT   = 6;
   localparam int FLAG_CRC_BIT      = 5;
   localparam int FLAG_RESTRICT_BIT = 4;

   localparam int SIZE_W = 28;
   localparam int CRC_W  = 35;
   localparam int POS_W  = 4;

   typedef enum logic [1:0] {
      ST_GOOD          = 2'd0,
      ST_SIZE_SMALL    = 2'd1,
      ST_SIZE_MISMATCH = 2'd2,
      ST_BAD_LENGTH    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SIZE,
      OP_FLAGS,
      OP_CRC,
      OP_RESTRICT
   } op_kind_type;

   // One classified byte handed from the front to the back.
   typedef struct packed {
      logic        start;
      op_kind_type kind;
      logic [7:0]  data;
      logic        last;
      status_type  status;
   } op_type;

endpackage

// ===== src/id3eh_front.sv =====
// Front end: accepts header bytes, tracks position, size and flags, runs all checks
// and classifies each byte into an op for the back end. Depends on id3eh_pkg.
module id3eh_front import id3eh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       start_req,
   output logic       push,
   output op_type     op
);

   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic              active_ff, active_in, active_eff;
   logic [SIZE_W-1:0] size_ff, size_in, size_eff;
   logic [2:0]        flags_ff, flags_in, flags_eff;
   logic [POS_W-1:0]  rel, crc_base, res_base, expect_sum;
   logic [POS_W:0]    pos_p1;
   logic              u, c, r;
   logic              len_bad, seen;

   always_comb begin
      pos_eff    = start_req ? '0 : pos_ff;
      active_eff = start_req | active_ff;
      size_eff   = start_req ? '0 : size_ff;
      flags_eff  = start_req ? '0 : flags_ff;

      pos_in    = pos_ff;
      active_in = active_ff;
      size_in   = size_ff;
      flags_in  = flags_ff;

      u = flags_eff[2];
      c = flags_eff[1];
      r = flags_eff[0];
      rel      = pos_eff - POS_W'(FLAG_BYTE_POS + 1);
      crc_base = {{(POS_W-1){1'b0}}, u};
      res_base = crc_base + (c ? POS_W'(CRC_SEG_BYTES) : '0);
      pos_p1   = {1'b0, pos_eff} + 1'b1;
      expect_sum = '0;
      len_bad  = 1'b0;
      seen     = 1'b0;

      push      = 1'b0;
      op.start  = start_req;
      op.kind   = OP_NONE;
      op.data   = data_byte;
      op.last   = 1'b0;
      op.status = ST_GOOD;

      if (accept && active_eff) begin
         push      = 1'b1;
         pos_in    = pos_eff + 1'b1;
         active_in = 1'b1;
         size_in   = size_eff;
         flags_in  = flags_eff;
         if (pos_eff < POS_W'(SIZE_BYTES)) begin
            op.kind = OP_SIZE;
            size_in = {size_eff[SIZE_W-8:0], data_byte[6:0]};
         end else if (pos_eff == POS_W'(FLAG_COUNT_POS)) begin
            op.kind = OP_NONE;
         end else if (pos_eff == POS_W'(FLAG_BYTE_POS)) begin
            op.kind  = OP_FLAGS;
            flags_in = {data_byte[FLAG_UPDATE_BIT], data_byte[FLAG_CRC_BIT],
                        data_byte[FLAG_RESTRICT_BIT]};
            expect_sum = POS_W'(MIN_SIZE) + {{(POS_W-1){1'b0}}, flags_in[2]}
                       + (flags_in[1] ? POS_W'(CRC_SEG_BYTES) : '0)
                       + (flags_in[0] ? POS_W'(RES_SEG_BYTES) : '0);
            if (size_eff < SIZE_W'(MIN_SIZE)) begin
               op.last   = 1'b1;
               op.status = ST_SIZE_SMALL;
            end else if (size_eff != {{(SIZE_W-POS_W){1'b0}}, expect_sum}) begin
               op.last   = 1'b1;
               op.status = ST_SIZE_MISMATCH;
            end else if (size_eff == SIZE_W'(MIN_SIZE)) begin
               op.last = 1'b1;
            end
         end else begin
            // flag data: find the segment holding this byte
            if (u && rel == '0) begin
               seen    = 1'b1;
               len_bad = (data_byte != 8'(UPDATE_LEN));
            end
            if (!seen && c && rel == crc_base) begin
               seen    = 1'b1;
               len_bad = (data_byte != 8'(CRC_LEN));
            end
            if (!seen && c && rel > crc_base
                && rel <= crc_base + POS_W'(CRC_LEN)) begin
               seen    = 1'b1;
               op.kind = OP_CRC;
            end
            if (!seen && r && rel == res_base) begin
               seen    = 1'b1;
               len_bad = (data_byte != 8'(RESTRICT_LEN));
            end
            if (!seen && r) begin
               op.kind = OP_RESTRICT;
            end
            if (len_bad) begin
               op.last   = 1'b1;
               op.status = ST_BAD_LENGTH;
            end else if ({{(SIZE_W-POS_W-1){1'b0}}, pos_p1} >= size_eff) begin
               op.last = 1'b1;
            end
         end
         if (op.last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         size_ff   <= '0;
         flags_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         size_ff   <= size_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

// ===== src/id3eh_queue.sv =====
// Two-entry op queue between front and back ends.
// Depends on id3eh_pkg for op_type.
module id3eh_queue import id3eh_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   op_type     mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/id3eh_back.sv =====
// Back end: applies ops to the size, flag, CRC and restriction accumulators and
// builds the result beat in the output register. Depends on id3eh_pkg.
module id3eh_back import id3eh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  op_type            head_op,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SIZE_W-1:0] rsp_header_size,
   output logic              rsp_update_flag,
   output logic              rsp_crc_present,
   output logic [CRC_W-1:0]  rsp_crc_value,
   output logic              rsp_restrict_present,
   output logic [1:0]        rsp_tag_size_limit,
   output logic              rsp_text_enc_limit,
   output logic [1:0]        rsp_text_size_limit,
   output logic              rsp_image_enc_limit,
   output logic [1:0]        rsp_image_size_limit
);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [2:0]        flags_ff, flags_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [7:0]        res_ff, res_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [SIZE_W-1:0] hsize_ff, hsize_in;
   logic [2:0]        oflags_ff, oflags_in;
   logic [CRC_W-1:0]  ocrc_ff, ocrc_in;
   logic [7:0]        ores_ff, ores_in;
   logic              good, flags_ok;

   always_comb begin
      pop = head_valid && (!rsp_valid_ff || !rsp_stall || !head_op.last);

      size_in  = size_ff;
      flags_in = flags_ff;
      crc_in   = crc_ff;
      res_in   = res_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      hsize_in     = hsize_ff;
      oflags_in    = oflags_ff;
      ocrc_in      = ocrc_ff;
      ores_in      = ores_ff;

      good     = (head_op.status == ST_GOOD);
      flags_ok = (head_op.status != ST_SIZE_SMALL);

      if (pop) begin
         if (head_op.start) begin
            size_in  = '0;
            flags_in = '0;
            crc_in   = '0;
            res_in   = '0;
         end
         case (head_op.kind)
            OP_SIZE:     size_in  = {size_in[SIZE_W-8:0], head_op.data[6:0]};
            OP_FLAGS:    flags_in = {head_op.data[FLAG_UPDATE_BIT],
                                     head_op.data[FLAG_CRC_BIT],
                                     head_op.data[FLAG_RESTRICT_BIT]};
            OP_CRC:      crc_in   = {crc_in[CRC_W-8:0], head_op.data[6:0]};
            OP_RESTRICT: res_in   = head_op.data;
            default:     ;
         endcase
         if (head_op.last) begin
            rsp_valid_in = 1'b1;
            status_in    = head_op.status;
            hsize_in     = size_in;
            oflags_in    = flags_ok ? flags_in : 3'b000;
            ocrc_in      = (good && flags_in[1]) ? crc_in : '0;
            ores_in      = (good && flags_in[0]) ? res_in : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         flags_ff     <= '0;
         crc_ff       <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         flags_ff     <= flags_in;
         crc_ff       <= crc_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      hsize_ff  <= hsize_in;
      oflags_ff <= oflags_in;
      ocrc_ff   <= ocrc_in;
      ores_ff   <= ores_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_header_size      = hsize_ff;
   assign rsp_update_flag      = oflags_ff[2];
   assign rsp_crc_present      = oflags_ff[1];
   assign rsp_crc_value        = ocrc_ff;
   assign rsp_restrict_present = oflags_ff[0];
   assign rsp_tag_size_limit   = ores_ff[7:6];
   assign rsp_text_enc_limit   = ores_ff[5];
   assign rsp_text_size_limit  = ores_ff[4:3];
   assign rsp_image_enc_limit  = ores_ff[2];
   assign rsp_image_size_limit = ores_ff[1:0];

endmodule

// ===== src/id3eh_core_top.sv =====
// ID3v2.4 extended header parser core.
//
// The req channel carries one header byte per beat; req_start_req marks the first
// byte of a new header and abandons any header in progress without a result.
// Bytes outside a header are dropped. The rsp channel carries one result beat per
// header: at the last byte of a good header or at the first error (size below
// six, size mismatch with the flags, bad flag-data length byte).
//
// Throughput: one byte per cycle while the queue has room. The front end classifies and
// checks each byte in the cycle it is accepted; a two-entry queue feeds the back end,
// which updates the accumulators and loads the result register as it pops each op.
// The final byte's op is registered in the queue and then popped into the result
// register, where the result beat becomes valid; a held result can delay that pop.
// Stall: while rsp_stall holds the result, the back end still drains bytes that do
// not end a header; only a second result waits, and req_stall rises when the
// queue fills.
// Reset (synchronous, active high) empties the queue, drops any result and
// leaves the parser idle until a start mark.
module id3_extended_header_parser_core import id3eh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_start_req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SIZE_W-1:0] rsp_header_size,
   output logic              rsp_update_flag,
   output logic              rsp_crc_present,
   output logic [CRC_W-1:0]  rsp_crc_value,
   output logic              rsp_restrict_present,
   output logic [1:0]        rsp_tag_size_limit,
   output logic              rsp_text_enc_limit,
   output logic [1:0]        rsp_text_size_limit,
   output logic              rsp_image_enc_limit,
   output logic [1:0]        rsp_image_size_limit
);

   logic   q_full, accept, push, pop, head_valid;
   op_type push_op, head_op;

   // Hold the input whenever the queue has no room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   id3eh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .start_req (req_start_req),
      .push      (push),
      .op        (push_op)
   );

   id3eh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   id3eh_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_op              (head_op),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_header_size      (rsp_header_size),
      .rsp_update_flag      (rsp_update_flag),
      .rsp_crc_present      (rsp_crc_present),
      .rsp_crc_value        (rsp_crc_value),
      .rsp_restrict_present (rsp_restrict_present),
      .rsp_tag_size_limit   (rsp_tag_size_limit),
      .rsp_text_enc_limit   (rsp_text_enc_limit),
      .rsp_text_size_limit  (rsp_text_size_limit),
      .rsp_image_enc_limit  (rsp_image_enc_limit),
      .rsp_image_size_limit (rsp_image_size_limit)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for id3_extended_header_parser_core: byte stream stimulus, scoreboard and checks.
// Depends on id3eh_pkg (status codes, field widths) and the core RTL only.
module testbench;
   import id3eh_pkg::*;

   // Header layout as the checker sees it, kept apart from the RTL package.
   localparam int HDR_MIN      = 6;
   localparam int LEN_UPDATE   = 0;
   localparam int LEN_CRC      = 5;
   localparam int LEN_RESTRICT = 1;
   localparam int LEN_CRC_SEG  = 6;
   localparam int LEN_RES_SEG  = 2;
   localparam int SIZE_BYTES_N = 4;
   localparam int FLAG_BYTE_AT = 5;

   typedef enum {
      HDR_GOOD,
      HDR_SIZE_SMALL,
      HDR_SIZE_MISMATCH,
      HDR_BAD_LENGTH,
      HDR_ABANDON,
      HDR_NOISE
   } hdr_mode_type;

   // One result beat, field for field as it leaves the core.
   typedef struct {
      status_type        status;
      logic [SIZE_W-1:0] header_size;
      logic              update_flag;
      logic              crc_present;
      logic [CRC_W-1:0]  crc_value;
      logic              restrict_present;
      logic [1:0]        tag_size_limit;
      logic              text_enc_limit;
      logic [1:0]        text_size_limit;
      logic              image_enc_limit;
      logic [1:0]        image_size_limit;
   } header_result_type;

   // Tracks the parse of the header stream and holds the results it must produce.
   class header_scoreboard;
      bit [3:0]          byte_pos;
      bit                in_header;
      bit [SIZE_W-1:0]   size_acc;
      bit [2:0]          flag_bits;      // update, crc, restrict
      bit [CRC_W-1:0]    crc_acc;
      bit [7:0]          restrict_bits;
      header_result_type expected_results[$];
      int                mismatches;
      int                results_checked;
      int                status_count[4];

      function void clear();
         byte_pos      = 0;
         in_header     = 0;
         size_acc      = 0;
         flag_bits     = 0;
         crc_acc       = 0;
         restrict_bits = 0;
      endfunction

      // Queue the result of the header in progress and go idle.
      function void close_header(status_type st);
         header_result_type r;
         bit good;
         bit flags_ok;
         bit [7:0] rb;
         good     = (st == ST_GOOD);
         flags_ok = (st != ST_SIZE_SMALL);
         rb       = (good && flag_bits[0]) ? restrict_bits : 8'h00;
         r.status           = st;
         r.header_size      = size_acc;
         r.update_flag      = flags_ok & flag_bits[2];
         r.crc_present      = flags_ok & flag_bits[1];
         r.restrict_present = flags_ok & flag_bits[0];
         r.crc_value        = (good && flag_bits[1]) ? crc_acc : '0;
         r.tag_size_limit   = rb[7:6];
         r.text_enc_limit   = rb[5];
         r.text_size_limit  = rb[4:3];
         r.image_enc_limit  = rb[2];
         r.image_size_limit = rb[1:0];
         expected_results.push_back(r);
         in_header = 0;
      endfunction

      function void close_if_last(int p);
         if (p + 1 >= size_acc)
            close_header(ST_GOOD);
      endfunction

      // Walk the present flag-data segments: update, then CRC, then restrictions.
      function void flag_data(bit [7:0] b, int p);
         int rel;
         rel = p - (FLAG_BYTE_AT + 1);
         if (flag_bits[2]) begin
            if (rel == 0) begin
               if (b != LEN_UPDATE) close_header(ST_BAD_LENGTH);
               else close_if_last(p);
               return;
            end
            rel = rel - 1;
         end
         if (flag_bits[1]) begin
            if (rel == 0) begin
               if (b != LEN_CRC) close_header(ST_BAD_LENGTH);
               else close_if_last(p);
               return;
            end
            if (rel < LEN_CRC_SEG) begin
               crc_acc = {crc_acc[CRC_W-8:0], b[6:0]};
               close_if_last(p);
               return;
            end
            rel = rel - LEN_CRC_SEG;
         end
         if (flag_bits[0]) begin
            if (rel == 0 && b != LEN_RESTRICT) begin
               close_header(ST_BAD_LENGTH);
               return;
            end
            if (rel != 0)
               restrict_bits = b;
         end
         close_if_last(p);
      endfunction

      // Note one accepted beat; return 1 when the parser consumed it.
      function bit note_byte(bit [7:0] b, bit first);
         int p;
         int want_size;
         if (first) begin
            clear();
            in_header = 1;
         end
         if (!in_header)
            return 0;
         p        = byte_pos;
         byte_pos = byte_pos + 1;
         if (p < SIZE_BYTES_N) begin
            size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
         end else if (p == FLAG_BYTE_AT) begin
            flag_bits = b[6:4];
            want_size = HDR_MIN + flag_bits[2] + LEN_CRC_SEG * flag_bits[1]
                        + LEN_RES_SEG * flag_bits[0];
            if (size_acc < HDR_MIN) close_header(ST_SIZE_SMALL);
            else if (size_acc != want_size) close_header(ST_SIZE_MISMATCH);
            else if (size_acc == HDR_MIN) close_header(ST_GOOD);
         end else if (p > FLAG_BYTE_AT) begin
            flag_data(b, p);
         end
         return 1;
      endfunction

      function void report(string field, logic [63:0] want_v, logic [63:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_result(header_result_type got);
         header_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result beat with no header pending: expected none, actual status %0d",
                     $time, got.status);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         status_count[want.status]++;
         report("status", want.status, got.status);
         report("header_size", want.header_size, got.header_size);
         report("update_flag", want.update_flag, got.update_flag);
         report("crc_present", want.crc_present, got.crc_present);
         report("crc_value", want.crc_value, got.crc_value);
         report("restrict_present", want.restrict_present, got.restrict_present);
         report("tag_size_limit", want.tag_size_limit, got.tag_size_limit);
         report("text_enc_limit", want.text_enc_limit, got.text_enc_limit);
         report("text_size_limit", want.text_size_limit, got.text_size_limit);
         report("image_enc_limit", want.image_enc_limit, got.image_enc_limit);
         report("image_size_limit", want.image_size_limit, got.image_size_limit);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 8'h00;
   logic              req_start_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [SIZE_W-1:0] rsp_header_size;
   logic              rsp_update_flag;
   logic              rsp_crc_present;
   logic [CRC_W-1:0]  rsp_crc_value;
   logic              rsp_restrict_present;
   logic [1:0]        rsp_tag_size_limit;
   logic              rsp_text_enc_limit;
   logic [1:0]        rsp_text_size_limit;
   logic              rsp_image_enc_limit;
   logic [1:0]        rsp_image_size_limit;

   header_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_used     = 0;
   bit hold_trigger   = 0;
   int hold_left      = 0;

   id3_extended_header_parser_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_start_req        (req_start_req),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_header_size      (rsp_header_size),
      .rsp_update_flag      (rsp_update_flag),
      .rsp_crc_present      (rsp_crc_present),
      .rsp_crc_value        (rsp_crc_value),
      .rsp_restrict_present (rsp_restrict_present),
      .rsp_tag_size_limit   (rsp_tag_size_limit),
      .rsp_text_enc_limit   (rsp_text_enc_limit),
      .rsp_text_size_limit  (rsp_text_size_limit),
      .rsp_image_enc_limit  (rsp_image_enc_limit),
      .rsp_image_size_limit (rsp_image_size_limit)
   );

   always #4 clock = ~clock;

   // Drive rsp_stall at the falling edge: a requested hold-off wins over random stalls.
   always @(negedge clock) begin
      if (hold_trigger) begin
         hold_left    = 200;
         hold_trigger = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Sample every accepted result beat at the rising edge and check it.
   always @(posedge clock) begin
      header_result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status           = status_type'(rsp_status);
         seen.header_size      = rsp_header_size;
         seen.update_flag      = rsp_update_flag;
         seen.crc_present      = rsp_crc_present;
         seen.crc_value        = rsp_crc_value;
         seen.restrict_present = rsp_restrict_present;
         seen.tag_size_limit   = rsp_tag_size_limit;
         seen.text_enc_limit   = rsp_text_enc_limit;
         seen.text_size_limit  = rsp_text_size_limit;
         seen.image_enc_limit  = rsp_image_enc_limit;
         seen.image_size_limit = rsp_image_size_limit;
         sb.check_result(seen);
      end
   end

   // Offer one beat from a falling edge, hold it until accepted, return at the next
   // falling edge. Idle cycles come first, so valid never reacts to stall.
   task automatic send_byte(input bit [7:0] b, input bit first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_start_req <= 1'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_start_req <= first;
      do @(posedge clock); while (req_stall);
      if (sb.note_byte(b, first))
         bytes_used++;
      @(negedge clock);
   endtask

   // Drop valid and hold the sender until every pending result has come out.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.expected_results.size() != 0);
   endtask

   function automatic bit [7:0] length_byte(bit [7:0] want, bit corrupt);
      bit [7:0] v;
      v = want;
      if (corrupt)
         do v = 8'($urandom); while (v == want);
      return v;
   endfunction

   // Build one header of a random kind with random content and send it.
   task automatic send_random_header();
      hdr_mode_type mode;
      bit [7:0]     beats[$];
      bit [7:0]     flag_byte;
      bit [27:0]    size_val;
      bit           u, c, r;
      int           pick, exp_size, bad_seg, cut;
      pick = $urandom_range(99);
      mode = pick < 50 ? HDR_GOOD : pick < 58 ? HDR_SIZE_SMALL :
             pick < 68 ? HDR_SIZE_MISMATCH : pick < 80 ? HDR_BAD_LENGTH :
             pick < 90 ? HDR_ABANDON : HDR_NOISE;
      if (mode == HDR_NOISE) begin
         // Loose bytes; an occasional start mark opens a header out of nowhere.
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(7) == 0);
         return;
      end
      {u, c, r} = 3'($urandom);
      if (mode == HDR_BAD_LENGTH && {u, c, r} == 3'b000)
         c = 1'b1;
      exp_size = HDR_MIN + u + LEN_CRC_SEG * c + LEN_RES_SEG * r;
      case (mode)
         HDR_SIZE_SMALL: size_val = 28'($urandom_range(HDR_MIN - 1));
         HDR_SIZE_MISMATCH: begin
            case ($urandom_range(2))
               0: do size_val = 28'($urandom_range(HDR_MIN, 20)); while (size_val == exp_size);
               1: do size_val = 28'($urandom);
                  while (size_val == exp_size || size_val < HDR_MIN);
               default: size_val = '1;
            endcase
         end
         default: size_val = 28'(exp_size);
      endcase
      // Synchsafe size, most significant group first, with random junk in bit 7.
      for (int i = 3; i >= 0; i--)
         beats.push_back({1'($urandom), size_val[7*i +: 7]});
      beats.push_back(8'($urandom));
      flag_byte      = 8'($urandom);
      flag_byte[6:4] = {u, c, r};
      beats.push_back(flag_byte);
      bad_seg = -1;
      if (mode == HDR_BAD_LENGTH)
         do bad_seg = $urandom_range(2);
         while (!(bad_seg == 0 ? u : bad_seg == 1 ? c : r));
      if (u)
         beats.push_back(length_byte(LEN_UPDATE, bad_seg == 0));
      if (c) begin
         beats.push_back(length_byte(LEN_CRC, bad_seg == 1));
         repeat (LEN_CRC) beats.push_back(8'($urandom));
      end
      if (r) begin
         beats.push_back(length_byte(LEN_RESTRICT, bad_seg == 2));
         beats.push_back(8'($urandom));
      end
      // Cut the header short; the next start mark abandons it.
      if (mode == HDR_ABANDON) begin
         cut = $urandom_range(1, beats.size() - 1);
         while (beats.size() > cut)
            void'(beats.pop_back());
      end
      foreach (beats[i])
         send_byte(beats[i], i == 0);
      // Trailing bytes after a finished header must be ignored.
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   // Hard stop in case the core hangs.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      bit [8:0] directed[$];
      int hdr_idx;
      int phase;
      int waited;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: {start, byte}. A stray byte before any start, the smallest good
      // header with bit 7 set in the size bytes, a size below six with all flags up,
      // and a full header with update, CRC and restrictions at all-ones content.
      directed = '{9'h05A,
                   9'h180, 9'h080, 9'h080, 9'h086, 9'h0FF, 9'h08F,
                   9'h100, 9'h000, 9'h000, 9'h000, 9'h000, 9'h070,
                   9'h180, 9'h000, 9'h080, 9'h08F, 9'h001, 9'h070, 9'h000, 9'h005,
                   9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h001, 9'h0FF};
      foreach (directed[i])
         send_byte(directed[i][7:0], directed[i][8]);

      // Random headers in phases of eight; drain between phases, and hold off
      // the receiver for a long stretch in the pressure phase to fill the core.
      hdr_idx = 0;
      while (bytes_used < 400) begin
         if (hdr_idx % 8 == 0) begin
            drain();
            phase = (hdr_idx / 8) % 5;
            case (phase)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
               3: begin send_idle_pct = 29; recv_stall_pct = 29; end
               default: begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 0;
                  hold_trigger   = 1;
               end
            endcase
         end
         send_random_header();
         hdr_idx++;
      end

      // Wind down: stop stalling, wait out every pending result, then the latency.
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (sb.expected_results.size() != 0 && waited < 5000);
      if (sb.expected_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  sb.expected_results.size());
         sb.mismatches += sb.expected_results.size();
      end
      repeat (8) @(negedge clock);

      $display("Run covered %0d parsed bytes over %0d random headers, %0d results checked,",
               bytes_used, hdr_idx, sb.results_checked);
      $display("  by status: good %0d, size below six %0d, size mismatch %0d, bad length %0d",
               sb.status_count[ST_GOOD], sb.status_count[ST_SIZE_SMALL],
               sb.status_count[ST_SIZE_MISMATCH], sb.status_count[ST_BAD_LENGTH]);
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/id3eh_pkg.sv
src/id3eh_front.sv
src/id3eh_queue.sv
src/id3eh_back.sv
src/id3eh_core_top.sv
test/testbench.sv
